### hw/rtl/rnmt_pkg.sv
// types and constants shared by the mapping table cells and the top level
package rnmt_pkg;

    localparam int GN_W  = 20;
    localparam int MN_W  = 8;
    localparam int CNT_W = 8;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // operation codes carried in tuser
    localparam logic [1:0] MODE_INSERT      = 2'd0;
    localparam logic [1:0] MODE_REMOVE      = 2'd1;
    localparam logic [1:0] MODE_QUERY_PAIR  = 2'd2;
    localparam logic [1:0] MODE_QUERY_GRAPH = 2'd3;

    // result status codes
    localparam logic [2:0] STAT_INCREMENTED = 3'd0;
    localparam logic [2:0] STAT_ADDED       = 3'd1;
    localparam logic [2:0] STAT_DECREMENTED = 3'd2;
    localparam logic [2:0] STAT_FREED       = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND   = 3'd4;
    localparam logic [2:0] STAT_FULL        = 3'd5;
    localparam logic [2:0] STAT_QUERY_DONE  = 3'd6;

    // update broadcast to every cell in the apply cycle
    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_INC,
        UPD_DEC,
        UPD_ADD
    } t_upd;

    typedef struct packed {
        logic             latch_hits; // capture compare results
        logic             bubble;     // close holes by one place
        t_upd             upd;
        logic             use_free;   // new pair goes to the free cell
        logic             any_graph;  // some cell matches the graph node
    } t_cmd;

    typedef struct packed {
        logic             valid;
        logic [GN_W-1:0]  graph_node;
        logic [MN_W-1:0]  motif_node;
        logic [CNT_W-1:0] refcount;
    } t_entry;

    typedef struct packed {
        logic pair;
        logic graph;
        logic motif;
    } t_hit;

endpackage

### hw/rtl/rnmt_cell.sv
// one table entry: compare against the broadcast pair, update, shift toward cell 0
module rnmt_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rnmt_pkg::t_cmd             i_cmd,
    input  logic [rnmt_pkg::GN_W-1:0]  i_graph_node,
    input  logic [rnmt_pkg::MN_W-1:0]  i_motif_node,
    input  logic                       i_at_free,
    input  logic                       i_left_valid,
    input  rnmt_pkg::t_entry           i_right,
    output rnmt_pkg::t_entry           o_entry,
    output rnmt_pkg::t_hit             o_hit,
    output logic [rnmt_pkg::CNT_W-1:0] o_cnt_pair,
    output logic [rnmt_pkg::CNT_W-1:0] o_cnt_graph
);

    logic                       r_valid;
    logic [rnmt_pkg::GN_W-1:0]  r_graph_node;
    logic [rnmt_pkg::MN_W-1:0]  r_motif_node;
    logic [rnmt_pkg::CNT_W-1:0] r_refcount;
    rnmt_pkg::t_hit             r_hit;

    logic                       n_valid;
    logic [rnmt_pkg::GN_W-1:0]  n_graph_node;
    logic [rnmt_pkg::MN_W-1:0]  n_motif_node;
    logic [rnmt_pkg::CNT_W-1:0] n_refcount;
    rnmt_pkg::t_hit             n_hit;

    logic g_eq;
    logic m_eq;
    logic write_new;

    assign g_eq = r_graph_node == i_graph_node;
    assign m_eq = r_motif_node == i_motif_node;

    // full table: reuse an evicted cell, the graph match first
    assign write_new = i_cmd.use_free ? i_at_free
                                      : (r_hit.graph | (~i_cmd.any_graph & r_hit.motif));

    always_comb begin
        n_valid      = r_valid;
        n_graph_node = r_graph_node;
        n_motif_node = r_motif_node;
        n_refcount   = r_refcount;
        n_hit        = r_hit;
        if (i_cmd.latch_hits) begin
            n_hit.pair  = r_valid & g_eq & m_eq;
            n_hit.graph = r_valid & g_eq;
            n_hit.motif = r_valid & m_eq;
        end
        if (i_cmd.bubble) begin
            if (!r_valid && i_right.valid) begin
                n_valid      = 1'b1;
                n_graph_node = i_right.graph_node;
                n_motif_node = i_right.motif_node;
                n_refcount   = i_right.refcount;
            end else if (r_valid && !i_left_valid) begin
                n_valid = 1'b0;
            end
        end
        case (i_cmd.upd)
            rnmt_pkg::UPD_INC: begin
                if (r_hit.pair && r_refcount != rnmt_pkg::CNT_MAX) begin
                    n_refcount = r_refcount + rnmt_pkg::CNT_ONE;
                end
            end
            rnmt_pkg::UPD_DEC: begin
                if (r_hit.pair) begin
                    if (r_refcount <= rnmt_pkg::CNT_ONE) begin
                        n_valid = 1'b0;
                    end else begin
                        n_refcount = r_refcount - rnmt_pkg::CNT_ONE;
                    end
                end
            end
            rnmt_pkg::UPD_ADD: begin
                if (write_new) begin
                    n_valid      = 1'b1;
                    n_graph_node = i_graph_node;
                    n_motif_node = i_motif_node;
                    n_refcount   = rnmt_pkg::CNT_ONE;
                end else if (r_hit.graph || r_hit.motif) begin
                    n_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= '0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_graph_node <= n_graph_node;
        r_motif_node <= n_motif_node;
        r_refcount   <= n_refcount;
    end

    assign o_entry.valid      = r_valid;
    assign o_entry.graph_node = r_graph_node;
    assign o_entry.motif_node = r_motif_node;
    assign o_entry.refcount   = r_refcount;
    assign o_hit              = r_hit;
    assign o_cnt_pair         = r_hit.pair  ? r_refcount : '0;
    assign o_cnt_graph        = r_hit.graph ? r_refcount : '0;

endmodule

### hw/rtl/refcounted_node_mapping_table.sv
// top level: control, result register and the row of table cells
//
// A table of up to MAX_ENTRIES graph-node to motif-node mappings with reference
// counts, held in a row of cells that each keep one entry. An operation is
// accepted when the block is idle and the table is packed; the cells compare it
// in the next cycle and apply the update in the APPLY state; no new operation is
// taken until the previous one has left APPLY. A remove that frees an entry, or
// an insert that evicts, leaves holes that the cells close by moving entries one
// place toward cell 0 per cycle while idle; acceptance waits for that. An
// operation is taken while an earlier result still waits on the output, but the
// update stalls until that result has been taken.
module refcounted_node_mapping_table #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // graph_node[19:0], motif_node[27:20], zero pad
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status[2:0], found[3], evicted[5:4],
                                       // entry_count[13:6], used_entries[18:14], zero pad
);

    localparam int UW = $clog2(MAX_ENTRIES + 1);
    localparam logic [UW-1:0] USED_MAX = UW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MATCH = 3'b010,
        ST_APPLY = 3'b100
    } t_state;

    t_state                     r_state, n_state;
    logic [1:0]                 r_mode;
    logic [rnmt_pkg::GN_W-1:0]  r_graph_node;
    logic [rnmt_pkg::MN_W-1:0]  r_motif_node;
    logic [UW-1:0]              r_used, n_used;
    logic                       r_out_valid, n_out_valid;
    logic [2:0]                 r_status, n_status;
    logic                       r_found, n_found;
    logic [1:0]                 r_evicted, n_evicted;
    logic [rnmt_pkg::CNT_W-1:0] r_count, n_count;

    rnmt_pkg::t_cmd             cmd;
    rnmt_pkg::t_upd             upd;
    rnmt_pkg::t_entry           entry   [MAX_ENTRIES];
    rnmt_pkg::t_hit             hit     [MAX_ENTRIES];
    logic [rnmt_pkg::CNT_W-1:0] cnt_p   [MAX_ENTRIES];
    logic [rnmt_pkg::CNT_W-1:0] cnt_g   [MAX_ENTRIES];

    logic                       any_pair, any_graph, any_motif;
    logic [rnmt_pkg::CNT_W-1:0] red_cnt_p, red_cnt_g;
    logic                       packed_ok;
    logic                       in_acc;
    logic                       out_free;
    logic                       full;
    logic [1:0]                 ev;
    logic [UW+4:0]              used_ext;

    assign in_acc   = s_axis_tvalid & s_axis_tready;
    assign out_free = ~r_out_valid | m_axis_tready;
    assign full     = r_used == USED_MAX;

    // reductions over the row
    always_comb begin
        any_pair  = 1'b0;
        any_graph = 1'b0;
        any_motif = 1'b0;
        red_cnt_p = '0;
        red_cnt_g = '0;
        packed_ok = 1'b1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            any_pair  = any_pair  | hit[i].pair;
            any_graph = any_graph | hit[i].graph;
            any_motif = any_motif | hit[i].motif;
            red_cnt_p = red_cnt_p | cnt_p[i];
            red_cnt_g = red_cnt_g | cnt_g[i];
        end
        for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
            packed_ok = packed_ok & ~(~entry[i].valid & entry[i+1].valid);
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) & packed_ok;

    // no entry matches both nodes when the pair is absent, so each side evicts at most one
    assign ev = {1'b0, any_graph} + {1'b0, any_motif};

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_status    = r_status;
        n_found     = r_found;
        n_evicted   = r_evicted;
        n_count     = r_count;
        upd         = rnmt_pkg::UPD_NONE;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_found     = 1'b0;
                    n_evicted   = 2'd0;
                    n_count     = '0;
                    case (r_mode)
                        rnmt_pkg::MODE_INSERT: begin
                            if (any_pair) begin
                                upd      = rnmt_pkg::UPD_INC;
                                n_status = rnmt_pkg::STAT_INCREMENTED;
                                n_count  = (red_cnt_p == rnmt_pkg::CNT_MAX) ? red_cnt_p
                                           : red_cnt_p + rnmt_pkg::CNT_ONE;
                            end else if (!any_graph && !any_motif && full) begin
                                n_status = rnmt_pkg::STAT_FULL;
                            end else begin
                                upd       = rnmt_pkg::UPD_ADD;
                                n_status  = rnmt_pkg::STAT_ADDED;
                                n_count   = rnmt_pkg::CNT_ONE;
                                n_evicted = ev;
                                n_used    = r_used + UW'(1) - UW'(ev);
                            end
                        end
                        rnmt_pkg::MODE_REMOVE: begin
                            if (!any_pair) begin
                                n_status = rnmt_pkg::STAT_NOT_FOUND;
                            end else if (red_cnt_p <= rnmt_pkg::CNT_ONE) begin
                                upd      = rnmt_pkg::UPD_DEC;
                                n_status = rnmt_pkg::STAT_FREED;
                                n_used   = r_used - UW'(1);
                            end else begin
                                upd      = rnmt_pkg::UPD_DEC;
                                n_status = rnmt_pkg::STAT_DECREMENTED;
                                n_count  = red_cnt_p - rnmt_pkg::CNT_ONE;
                            end
                        end
                        rnmt_pkg::MODE_QUERY_PAIR: begin
                            n_status = rnmt_pkg::STAT_QUERY_DONE;
                            n_found  = any_pair;
                            n_count  = red_cnt_p;
                        end
                        rnmt_pkg::MODE_QUERY_GRAPH: begin
                            n_status = rnmt_pkg::STAT_QUERY_DONE;
                            n_found  = any_graph;
                            n_count  = red_cnt_g;
                        end
                        default: begin
                            n_status = rnmt_pkg::STAT_QUERY_DONE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.latch_hits = r_state == ST_MATCH;
        cmd.bubble     = r_state == ST_IDLE;
        cmd.upd        = upd;
        cmd.use_free   = ~full;
        cmd.any_graph  = any_graph;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode       <= s_axis_tuser;
            r_graph_node <= s_axis_tdata[rnmt_pkg::GN_W-1:0];
            r_motif_node <= s_axis_tdata[rnmt_pkg::GN_W +: rnmt_pkg::MN_W];
        end
        r_status  <= n_status;
        r_found   <= n_found;
        r_evicted <= n_evicted;
        r_count   <= n_count;
    end

    for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
        rnmt_pkg::t_entry right;
        logic             left_valid;

        if (gi == MAX_ENTRIES - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid
            assign right = entry[gi+1];
        end

        if (gi == 0) begin : g_first
            assign left_valid = 1'b1;
        end else begin : g_rest
            assign left_valid = entry[gi-1].valid;
        end

        rnmt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (cmd),
            .i_graph_node (r_graph_node),
            .i_motif_node (r_motif_node),
            .i_at_free    (r_used == UW'(gi)),
            .i_left_valid (left_valid),
            .i_right      (right),
            .o_entry      (entry[gi]),
            .o_hit        (hit[gi]),
            .o_cnt_pair   (cnt_p[gi]),
            .o_cnt_graph  (cnt_g[gi])
        );
    end

    assign used_ext      = {5'd0, r_used};
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, used_ext[4:0], r_count, r_evicted, r_found, r_status};

endmodule

### sim/tb_top.sv
// self-checking testbench for the refcounted node mapping table
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 400000;
    localparam int GN_W        = rnmt_pkg::GN_W;
    localparam int MN_W        = rnmt_pkg::MN_W;
    localparam int CNT_W       = rnmt_pkg::CNT_W;

    // result fields as they sit in m_axis_tdata[18:0], lowest field last
    typedef struct packed {
        logic [4:0]       used_entries;
        logic [CNT_W-1:0] entry_count;
        logic [1:0]       evicted;
        logic             found;
        logic [2:0]       status;
    } t_map_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;  // graph_node[19:0], motif_node[27:20], zero pad
    logic [1:0]  s_axis_tuser = '0;  // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;       // status[2:0], found[3], evicted[5:4],
                                     // entry_count[13:6], used_entries[18:14], zero pad

    // mirror of the mapping store
    logic             map_valid [TABLE_DEPTH];
    logic [GN_W-1:0]  map_graph [TABLE_DEPTH];
    logic [MN_W-1:0]  map_motif [TABLE_DEPTH];
    logic [CNT_W-1:0] map_count [TABLE_DEPTH];

    t_map_result pending_results[$];
    int          n_fail = 0;
    int          cycle_cnt = 0;
    int          burst_left = 0;
    bit          tx_gaps = 1'b1;
    int          hold_req_cnt = 0;
    int          hold_done_cnt = 0;

    refcounted_node_mapping_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // applies one operation to the mirrored store and returns the result it gives
    function automatic t_map_result apply_mapping_op(input logic [1:0] op,
                                                     input logic [GN_W-1:0] g,
                                                     input logic [MN_W-1:0] m);
        t_map_result r;
        int          hit;
        int          slot;
        int          used;
        logic        conflict;
        r = '0;
        hit = -1;
        slot = -1;
        used = 0;
        conflict = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (hit < 0 && map_valid[i] && map_graph[i] == g &&
                (op == rnmt_pkg::MODE_QUERY_GRAPH || map_motif[i] == m))
                hit = i;
        end
        case (op)
            rnmt_pkg::MODE_INSERT: begin
                if (hit >= 0) begin
                    if (map_count[hit] != rnmt_pkg::CNT_MAX)
                        map_count[hit]++;
                    r.status = rnmt_pkg::STAT_INCREMENTED;
                    r.entry_count = map_count[hit];
                end else begin
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (map_valid[i] && (map_graph[i] == g || map_motif[i] == m))
                            conflict = 1'b1;
                        if (!map_valid[i] && slot < 0)
                            slot = i;
                    end
                    if (!conflict && slot < 0) begin
                        r.status = rnmt_pkg::STAT_FULL;
                    end else begin
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (map_valid[i] && (map_graph[i] == g || map_motif[i] == m)) begin
                                map_valid[i] = 1'b0;
                                r.evicted++;
                            end
                        end
                        slot = -1;
                        for (int i = 0; i < TABLE_DEPTH; i++) begin
                            if (!map_valid[i] && slot < 0)
                                slot = i;
                        end
                        map_valid[slot] = 1'b1;
                        map_graph[slot] = g;
                        map_motif[slot] = m;
                        map_count[slot] = rnmt_pkg::CNT_ONE;
                        r.status = rnmt_pkg::STAT_ADDED;
                        r.entry_count = rnmt_pkg::CNT_ONE;
                    end
                end
            end
            rnmt_pkg::MODE_REMOVE: begin
                if (hit < 0) begin
                    r.status = rnmt_pkg::STAT_NOT_FOUND;
                end else if (map_count[hit] <= rnmt_pkg::CNT_ONE) begin
                    map_valid[hit] = 1'b0;
                    r.status = rnmt_pkg::STAT_FREED;
                end else begin
                    map_count[hit]--;
                    r.status = rnmt_pkg::STAT_DECREMENTED;
                    r.entry_count = map_count[hit];
                end
            end
            default: begin
                r.status = rnmt_pkg::STAT_QUERY_DONE;
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.entry_count = map_count[hit];
                end
            end
        endcase
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (map_valid[i])
                used++;
        r.used_entries = used[4:0];
        return r;
    endfunction

    // offers one operation; the sender idles between bursts of random length when tx_gaps is set
    task automatic send_op(input logic [1:0] op, input logic [GN_W-1:0] g,
                           input logic [MN_W-1:0] m);
        t_map_result res;
        if (burst_left == 0) begin
            if (tx_gaps) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, m, g};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        res = apply_mapping_op(op, g, m);
        pending_results = {pending_results, res};
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_map_result want;
        t_map_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_map_result'(m_axis_tdata[18:0]);
            if (pending_results.size() == 0) begin
                $error("result transaction with no operation pending: %h", m_axis_tdata);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, got.status);
                check_field("found", want.found, got.found);
                check_field("evicted", want.evicted, got.evicted);
                check_field("entry_count", want.entry_count, got.entry_count);
                check_field("used_entries", want.used_entries, got.used_entries);
                check_field("pad", 0, m_axis_tdata[23:19]);
            end
        end
    end

    // receiver: ready level changes per segment, plus long hold-offs on request
    initial begin : rx_stall_pattern
        int seg_left;
        int ready_pct;
        seg_left = 0;
        ready_pct = 100;
        forever begin
            @(posedge i_clk);
            if (hold_req_cnt != hold_done_cnt) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done_cnt++;
            end
            if (seg_left == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 80;
                    2: ready_pct = 50;
                    default: ready_pct = 20;
                endcase
                seg_left = $urandom_range(16, 96);
            end
            seg_left--;
            m_axis_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    task automatic test_directed_cases();
        send_op(rnmt_pkg::MODE_QUERY_GRAPH, '0, MN_W'($urandom));
        send_op(rnmt_pkg::MODE_REMOVE, '1, '1);
        send_op(rnmt_pkg::MODE_INSERT, '0, '0);
        send_op(rnmt_pkg::MODE_INSERT, '0, '0);
        send_op(rnmt_pkg::MODE_QUERY_PAIR, '0, '0);
        send_op(rnmt_pkg::MODE_QUERY_PAIR, '0, '1);
        send_op(rnmt_pkg::MODE_INSERT, '1, '1);
        send_op(rnmt_pkg::MODE_QUERY_GRAPH, '1, '0);
        // shares graph with one entry and motif with the other
        send_op(rnmt_pkg::MODE_INSERT, '1, '0);
        send_op(rnmt_pkg::MODE_REMOVE, '1, '0);
        send_op(rnmt_pkg::MODE_INSERT, 20'h00005, 8'h07);
        send_op(rnmt_pkg::MODE_INSERT, 20'h00005, 8'h07);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h00005, 8'h07);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h00005, 8'h07);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h00005, 8'h07);
        send_op(rnmt_pkg::MODE_INSERT, 20'h00005, 8'h09);
        send_op(rnmt_pkg::MODE_INSERT, 20'h00006, 8'h09);
        send_op(rnmt_pkg::MODE_QUERY_PAIR, 20'h00005, 8'h09);
        send_op(rnmt_pkg::MODE_QUERY_GRAPH, 20'h00006, MN_W'($urandom));
        send_op(rnmt_pkg::MODE_QUERY_GRAPH, 20'h00005, MN_W'($urandom));
        send_op(rnmt_pkg::MODE_INSERT, 20'hAAAAA, 8'h55);
        send_op(rnmt_pkg::MODE_INSERT, 20'h55555, 8'hAA);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h55555, 8'h55);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < TABLE_DEPTH + 1; i++)
            send_op(rnmt_pkg::MODE_INSERT, GN_W'(20'h80000 + i), MN_W'(8'h80 + i));
        // new pair with no conflict into a full table
        send_op(rnmt_pkg::MODE_INSERT, 20'h7FFFF, 8'hF0);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h80002, 8'h82);
        send_op(rnmt_pkg::MODE_INSERT, 20'h80003, 8'hF0);
        send_op(rnmt_pkg::MODE_INSERT, 20'h80004, 8'h85);
        send_op(rnmt_pkg::MODE_QUERY_GRAPH, 20'h80003, 8'h00);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h80003, 8'hF0);
    endtask

    task automatic test_count_saturation();
        for (int i = 0; i < 258; i++)
            send_op(rnmt_pkg::MODE_INSERT, 20'h12345, 8'h5A);
        send_op(rnmt_pkg::MODE_QUERY_PAIR, 20'h12345, 8'h5A);
        send_op(rnmt_pkg::MODE_REMOVE, 20'h12345, 8'h5A);
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_output_backpressure();
        tx_gaps = 1'b0;
        hold_req_cnt++;
        for (int i = 0; i < 12; i++)
            send_op(rnmt_pkg::MODE_INSERT, GN_W'(20'h30000 + i % 4), MN_W'(8'h30 + i % 5));
        tx_gaps = 1'b1;
    endtask

    task automatic test_random_mix(input int n_items);
        logic [GN_W-1:0] graph_pool [24];
        logic [MN_W-1:0] motif_pool [24];
        int              live [$];
        int              span;
        int              pick;
        int              kind;
        logic [1:0]      op;
        logic [GN_W-1:0] g;
        logic [MN_W-1:0] m;
        span = 8;
        for (int i = 0; i < 24; i++) begin
            graph_pool[i] = GN_W'($urandom);
            motif_pool[i] = MN_W'($urandom);
        end
        graph_pool[0] = '0;
        graph_pool[1] = '1;
        motif_pool[0] = '0;
        motif_pool[1] = '1;
        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0) begin
                span = $urandom_range(3, 24);
                tx_gaps = ($urandom_range(0, 2) != 0);
            end
            g = graph_pool[$urandom_range(0, span - 1)];
            m = motif_pool[$urandom_range(0, span - 1)];
            kind = $urandom_range(0, 99);
            live.delete();
            for (int i = 0; i < TABLE_DEPTH; i++)
                if (map_valid[i])
                    live = {live, i};
            if (kind < 8) begin
                g = GN_W'($urandom);
                m = MN_W'($urandom);
            end else if (kind < 55 && live.size() > 0) begin
                // aim at a pair that is currently stored
                pick = live[$urandom_range(0, live.size() - 1)];
                g = map_graph[pick];
                m = map_motif[pick];
            end
            kind = $urandom_range(0, 99);
            if (kind < 40)
                op = rnmt_pkg::MODE_INSERT;
            else if (kind < 70)
                op = rnmt_pkg::MODE_REMOVE;
            else if (kind < 85)
                op = rnmt_pkg::MODE_QUERY_PAIR;
            else
                op = rnmt_pkg::MODE_QUERY_GRAPH;
            send_op(op, g, m);
        end
        tx_gaps = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            map_valid[i] = 1'b0;
            map_graph[i] = '0;
            map_motif[i] = '0;
            map_count[i] = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_table_full();
        test_count_saturation();
        test_output_backpressure();
        test_random_mix(530);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
